// ===== rtl/positional_list_engine_macros.svh =====
// assertion macros used by the list engine checker
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// same-cycle implication, quiet during reset
`define PL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define PL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also covers reset itself
`define PL_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pl_pkg.sv =====
// types and operation codes of the positional list engine
package pl_pkg;

  typedef logic [2:0]  func_t;
  typedef logic [4:0]  pos_t;
  typedef logic [31:0] word_t;

  localparam func_t FN_INS_FRONT = 3'd0;
  localparam func_t FN_EXT_FRONT = 3'd1;
  localparam func_t FN_INS_BACK  = 3'd2;
  localparam func_t FN_EXT_BACK  = 3'd3;
  localparam func_t FN_INS_AT    = 3'd4;
  localparam func_t FN_EXT_AT    = 3'd5;

  // broadcast command to every cell of the chain
  typedef struct packed {
    logic ins;
    logic ext;
  } cell_cmd_t;

endpackage

// ===== rtl/pl_req_if.sv =====
// request channel: operation, position and value
interface pl_req_if;
  import pl_pkg::*;

  logic  valid;
  logic  ready;
  func_t func;
  pos_t  position;
  word_t value_in;

  modport source (output valid, func, position, value_in, input ready);
  modport sink   (input valid, func, position, value_in, output ready);
endinterface

// ===== rtl/pl_rsp_if.sv =====
// response channel: status, extracted value and count
interface pl_rsp_if;
  import pl_pkg::*;

  logic  valid;
  logic  ready;
  logic  ok;
  word_t value_out;
  pos_t  count;

  modport source (output valid, ok, value_out, count, input ready);
  modport sink   (input valid, ok, value_out, count, output ready);
endinterface

// ===== rtl/pl_cell.sv =====
// one list cell: holds one entry and shifts toward either neighbor
module pl_cell #(
  parameter int IDX_W = 4,
  parameter int INDEX = 0,
  parameter int WIDTH = 32
) (
  input  logic                 clk,
  input  pl_pkg::cell_cmd_t    cmd,
  input  logic [IDX_W-1:0]     idx,
  input  logic [WIDTH-1:0]     value,
  input  logic [WIDTH-1:0]     left,
  input  logic [WIDTH-1:0]     right,
  output logic [WIDTH-1:0]     data
);
  import pl_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [WIDTH-1:0] data_next;

  always_comb begin
    data_next = data;
    if (cmd.ins) begin
      if (MY_IDX == idx) begin
        data_next = value;
      end else if (MY_IDX > idx) begin
        data_next = left;
      end
    end else if (cmd.ext) begin
      if (MY_IDX >= idx) begin
        data_next = right;
      end
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end
endmodule

// ===== rtl/positional_list_engine.sv =====
// top level of the positional list engine
//
// bounded ordered list of up to DEPTH entries of WIDTH bits, position 1 at
// the head. one request transaction on req carries func, position and
// value_in; each one yields exactly one response transaction on rsp with
// ok, value_out (extracted entry, else zero) and count after the operation.
//
// every operation, positional ones included, updates the list at once: the
// entries sit in a chain of cells, and every cell from the position onward
// shifts by one place or takes the new value in the same clock. the response
// is registered, and a new request is taken every cycle while rsp keeps up.
//
// receiver stall: the response register holds its transaction and req.ready
// drops until rsp.ready returns; no request is lost or reordered.
//
// reset (rst, synchronous) empties the list, drops rsp.valid and holds
// req.ready low; entry contents are left as they are since no read can
// reach past the count.
module positional_list_engine #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input logic      clk,
  input logic      rst,
  pl_req_if.sink   req,
  pl_rsp_if.source rsp
);
  import pl_pkg::*;

  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  // compare width: wide enough for count, position and count plus one
  localparam int CMPW = ((CW > 5) ? CW : 5) + 1;

  logic [CW-1:0]    held;
  logic [CW-1:0]    held_next;
  logic [WIDTH-1:0] ent [DEPTH];

  logic             accept;
  logic             is_ins;
  logic             is_ext;
  logic [CMPW-1:0]  sel_pos;
  logic [CMPW-1:0]  sel_m1;
  logic [CMPW-1:0]  held_w;
  logic [CMPW-1:0]  pos_w;
  logic [CMPW-1:0]  hn_w;
  logic             ins_ok;
  logic             ext_ok;
  logic [IW-1:0]    idx;
  logic [63:0]      vin_w;
  logic [WIDTH-1:0] vin;
  logic [63:0]      got_w;
  cell_cmd_t        cmd;

  // a new request is taken whenever the response slot frees up, never in reset
  assign req.ready = !rst && (!rsp.valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  assign held_w = CMPW'(held);
  assign pos_w  = CMPW'(req.position);

  // decode to an insert or extract at a one-based position
  always_comb begin
    is_ins  = 1'b0;
    is_ext  = 1'b0;
    sel_pos = '0;
    case (req.func)
      FN_INS_FRONT: begin
        is_ins  = 1'b1;
        sel_pos = CMPW'(1);
      end
      FN_EXT_FRONT: begin
        is_ext  = 1'b1;
        sel_pos = CMPW'(1);
      end
      FN_INS_BACK: begin
        is_ins  = 1'b1;
        sel_pos = held_w + CMPW'(1);
      end
      FN_EXT_BACK: begin
        is_ext  = 1'b1;
        sel_pos = held_w;
      end
      FN_INS_AT: begin
        is_ins  = 1'b1;
        sel_pos = pos_w;
      end
      FN_EXT_AT: begin
        is_ext  = 1'b1;
        sel_pos = pos_w;
      end
      default: begin
        // unused codes leave the list alone and report failure
        is_ins  = 1'b0;
        is_ext  = 1'b0;
      end
    endcase
  end

  // insert needs room and a position in 1..count+1
  assign ins_ok = is_ins && (held_w < CMPW'(DEPTH)) && (sel_pos != '0)
                  && (sel_pos <= held_w + CMPW'(1));
  // extract needs an entry and a position in 1..count
  assign ext_ok = is_ext && (held_w != '0) && (sel_pos != '0) && (sel_pos <= held_w);

  assign sel_m1 = sel_pos - CMPW'(1);
  assign idx    = sel_m1[IW-1:0];

  assign cmd.ins = accept && ins_ok;
  assign cmd.ext = accept && ext_ok;

  assign vin_w = 64'(req.value_in);
  assign vin   = vin_w[WIDTH-1:0];

  // chain of cells; each takes from its left neighbor on insert and from
  // its right neighbor on extract, the head takes the input value as its left and the tail folds back on itself
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] left;
    logic [WIDTH-1:0] right;
    if (i == 0) begin : g_head
      assign left = vin;
    end else begin : g_mid_l
      assign left = ent[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right = ent[i];
    end else begin : g_mid_r
      assign right = ent[i+1];
    end
    pl_cell #(
      .IDX_W (IW),
      .INDEX (i),
      .WIDTH (WIDTH)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .idx   (idx),
      .value (vin),
      .left  (left),
      .right (right),
      .data  (ent[i])
    );
  end

  // entry read for the extracted value, zero-extended or cut to 32 bits
  assign got_w = 64'(ent[idx]);

  always_comb begin
    held_next = held;
    if (ins_ok) begin
      held_next = held + CW'(1);
    end else if (ext_ok) begin
      held_next = held - CW'(1);
    end
  end

  assign hn_w = CMPW'(held_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        held      <= held_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.ok        <= ins_ok || ext_ok;
      rsp.value_out <= ext_ok ? got_w[31:0] : '0;
      rsp.count     <= hn_w[4:0];
    end
  end
endmodule

// ===== rtl/pl_checker.sv =====
// port-level checks of the list engine, bound to the top level
`include "positional_list_engine_macros.svh"

module pl_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input logic          rsp_ok,
  input pl_pkg::word_t rsp_value_out,
  input pl_pkg::pos_t  rsp_count
);
  import pl_pkg::*;

  pos_t last_count;

  // count reported by the last delivered response, zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      last_count <= '0;
    end else if (rsp_valid && rsp_ready) begin
      last_count <= rsp_count;
    end
  end

  `PL_ASSERT_ALWAYS(a_reset_idle, rst, !rsp_valid, "response valid right after reset")
  `PL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
    rsp_valid && $stable(rsp_ok) && $stable(rsp_value_out) && $stable(rsp_count),
    "stalled response changed")
  `PL_ASSERT_NOW(a_stall_blocks, rsp_valid && !rsp_ready, !req_ready,
    "request taken while response stalled")
  `PL_ASSERT_NOW(a_fail_clean, rsp_valid && !rsp_ok,
    (rsp_value_out == '0) && (rsp_count == last_count),
    "rejected operation changed count or returned data")
endmodule

bind positional_list_engine pl_checker u_pl_checker (
  .clk           (clk),
  .rst           (rst),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_ok        (rsp.ok),
  .rsp_value_out (rsp.value_out),
  .rsp_count     (rsp.count)
);
